// ===== design/rar_pkg.sv =====
// shared constants and types for the rational arithmetic reducer
package rar_pkg;
  localparam int OpW = 16;
  localparam int ProdW = 2 * OpW;
  localparam int SumW = ProdW + 1;
  localparam int MagW = SumW;
  localparam int NumW = 32;
  localparam int DenW = 31;
  localparam int CntW = $clog2(MagW + 1);

  typedef enum logic [2:0] {
    KIND_SUM  = 3'd0,
    KIND_DIFF = 3'd1,
    KIND_PROD = 3'd2,
    KIND_QUOT = 3'd3,
    KIND_MAX  = 3'd4
  } kind_t;

  typedef struct packed {
    logic start;
    logic [MagW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [MagW-1:0] quot;
    logic [MagW-1:0] rem;
  } div_rsp_t;
endpackage

// ===== design/rar_div.sv =====
// shared restoring divider, one quotient bit per cycle
module rar_div import rar_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [MagW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [MagW:0] trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[MagW-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend; r_nxt = '0; d_nxt = req.divisor;
      cnt_nxt = CntW'(MagW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[MagW]) begin
        r_nxt = trial[MagW-1:0];
        q_nxt = {q_r[MagW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[MagW-2:0], q_r[MagW-1]};
        q_nxt = {q_r[MagW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) $rose(busy_r) |-> cnt_r == CntW'(MagW))
    else $error("divider count not loaded");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r || $past(req.start, 1))
    else $error("divider done held");
endmodule

// ===== design/rational_arith_reduce.sv =====
// rational_arith_reduce: fraction arithmetic with euclid gcd reduction
// sequence: accept, four products, operand setup, then euclid gcd steps and two divisions by
//   the gcd, skipped when the numerator or denominator is zero; later results repeat it from setup
// flow: one input word at a time; in_tready returns once the last result is loaded
//   into the output register
// reset: rst_n synchronous active low, returns the sequencer to idle, output empty
module rational_arith_reduce import rar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // a_num, a_den, b_num, b_den
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // negative, num_mag, den_mag
  output logic [3:0]  out_tuser, // op_kind, div_error
  output logic        out_tlast  // last
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SETUP, S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic signed [OpW-1:0] ax_r, ay_r, bx_r, by_r;
  logic func_r, func_nxt;
  logic signed [ProdW-1:0] p1_r, p2_r, p3_r, p4_r, p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic signed [SumW-1:0] n_r, d_r, n_nxt, d_nxt;
  logic [MagW-1:0] ga_r, gb_r, ga_nxt, gb_nxt, nq_r, nq_nxt;
  logic wait_r, wait_nxt;
  logic ov_r, ov_nxt;
  logic [63:0] od_r, od_nxt;
  logic [3:0] ou_r, ou_nxt;
  logic ol_r, ol_nxt;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [OpW-1:0] ma, mb;
  logic signed [ProdW-1:0] mp;
  logic [MagW-1:0] nm, dm;
  kind_t kind;
  logic neg;

  rar_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign mp = ma * mb;
  assign nm = n_r[SumW-1] ? MagW'(-n_r) : MagW'(n_r);
  assign dm = d_r[SumW-1] ? MagW'(-d_r) : MagW'(d_r);

  always_comb begin
    state_nxt = state_r; func_nxt = func_r;
    p1_nxt = p1_r; p2_nxt = p2_r; p3_nxt = p3_r; p4_nxt = p4_r;
    idx_nxt = idx_r; n_nxt = n_r; d_nxt = d_r; ga_nxt = ga_r; gb_nxt = gb_r;
    nq_nxt = nq_r; wait_nxt = wait_r; ov_nxt = ov_r; od_nxt = od_r; ou_nxt = ou_r;
    ol_nxt = ol_r;
    dreq = '0; ma = ax_r; mb = by_r;
    kind = func_r ? KIND_MAX : kind_t'(idx_r);
    neg = n_r[SumW-1] != d_r[SumW-1];
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_tvalid) begin
        func_nxt = in_tuser; idx_nxt = '0; state_nxt = S_MUL1;
      end
      // four products through one multiplier
      S_MUL1: begin
        case (idx_r)
          3'd0: begin ma = ax_r; mb = by_r; p1_nxt = mp; end
          3'd1: begin ma = bx_r; mb = ay_r; p2_nxt = mp; end
          3'd2: begin ma = ax_r; mb = bx_r; p3_nxt = mp; end
          default: begin ma = ay_r; mb = by_r; p4_nxt = mp; end
        endcase
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 3'd3) begin idx_nxt = '0; state_nxt = S_MUL2; end
      end
      S_MUL2: begin
        state_nxt = S_SETUP;
        if (func_r) begin
          // nax*nby > nbx*nay, exactly one negative denominator flips the comparison
          if ((ay_r[OpW-1] ^ by_r[OpW-1]) ? (p1_r < p2_r) : (p1_r > p2_r)) begin
            n_nxt = SumW'(ax_r); d_nxt = SumW'(ay_r);
          end else begin
            n_nxt = SumW'(bx_r); d_nxt = SumW'(by_r);
          end
        end else begin
          n_nxt = SumW'(p1_r) + SumW'(p2_r); d_nxt = SumW'(p4_r);
        end
      end
      S_SETUP: begin
        ga_nxt = nm; gb_nxt = dm; wait_nxt = 1'b0;
        if (dm == '0 || nm == '0) state_nxt = S_OUT;
        else state_nxt = S_GCD;
      end
      S_GCD: begin
        if (!wait_r) begin
          if (gb_r == '0) begin
            dreq.start = 1'b1; dreq.dividend = nm; dreq.divisor = ga_r;
            wait_nxt = 1'b1; state_nxt = S_DIVN;
          end else begin
            dreq.start = 1'b1; dreq.dividend = ga_r; dreq.divisor = gb_r;
            wait_nxt = 1'b1;
          end
        end else if (drsp.done) begin
          ga_nxt = gb_r; gb_nxt = drsp.rem; wait_nxt = 1'b0;
        end
      end
      S_DIVN: if (drsp.done) begin
        nq_nxt = drsp.quot; dreq.start = 1'b1; dreq.dividend = dm; dreq.divisor = ga_r;
        state_nxt = S_DIVD;
      end
      S_DIVD: if (drsp.done) begin
        ga_nxt = drsp.quot; state_nxt = S_OUT;
      end
      default: begin // S_OUT
        if (!ov_r || out_tready) begin
          od_nxt = '0;
          ou_nxt = '0;
          ou_nxt[2:0] = kind;
          if (dm == '0) ou_nxt[3] = 1'b1;
          else if (nm == '0) od_nxt[63:33] = DenW'(1);
          else begin
            od_nxt[0] = neg;
            od_nxt[32:1] = nq_r[NumW-1:0];
            od_nxt[63:33] = ga_r[DenW-1:0];
          end
          ol_nxt = func_r || idx_r == 3'd3;
          ov_nxt = 1'b1;
          if (ol_nxt) state_nxt = S_IDLE;
          else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_SETUP;
            case (idx_r)
              3'd0: begin n_nxt = SumW'(p1_r) - SumW'(p2_r); d_nxt = SumW'(p4_r); end
              3'd1: begin n_nxt = SumW'(p3_r); d_nxt = SumW'(p4_r); end
              default: begin
                // quotient denominator ay*bx from the idle multiplier
                ma = ay_r; mb = bx_r;
                n_nxt = SumW'(p1_r); d_nxt = SumW'(mp);
              end
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; wait_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; wait_r <= wait_nxt;
    end
    if (state_r == S_IDLE && in_tvalid) begin
      ax_r <= in_tdata[15:0]; ay_r <= in_tdata[31:16];
      bx_r <= in_tdata[47:32]; by_r <= in_tdata[63:48];
    end
    func_r <= func_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt; p3_r <= p3_nxt; p4_r <= p4_nxt;
    idx_r <= idx_nxt; n_r <= n_nxt; d_r <= d_nxt; ga_r <= ga_nxt; gb_r <= gb_nxt;
    nq_r <= nq_nxt; od_r <= od_nxt; ou_r <= ou_nxt; ol_r <= ol_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled word changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && in_tvalid |=> state_r == S_MUL1)
    else $error("accept did not start");
endmodule
